@@ design/nnrs_pkg.sv @@
// Shared types and constants of the nearest-neighbor RGB scaler.
package nnrs_pkg;

  // Size registers and the fixed-point format of the steps.
  localparam int SZW = 9;
  localparam int SZ_MAX = (2 ** SZW) - 1;
  localparam int FRACW = 16;
  localparam int DVW = SZW + FRACW;
  localparam int ACCW = 32;
  localparam int PIXW = 24;
  localparam int CFG_IDXW = 2;

  // Entries of the queue between the front end and the back end.
  localparam int QDEPTH = 2;

  typedef logic [PIXW-1:0] pixel_t;

  typedef enum logic [CFG_IDXW-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FS_RUN     = 2'd0,
    FS_DIV_ROW = 2'd1,
    FS_DIV_COL = 2'd2
  } front_state_e;

  typedef struct packed {
    logic last_in_row;
    logic last_in_frame;
    logic not_loaded;
  } rd_flags_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/nnrs_div.sv @@
// Restoring divider that produces one quotient bit per cycle for the step values.
module nnrs_div import nnrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVW-1:0]   num_i,
  input  logic [SZW-1:0]   den_i,
  output div_stat_t        stat_o,
  output logic [DVW-1:0]   quot_o
);

  localparam int CNTW = $clog2(DVW + 1);

  logic [DVW-1:0]  quot_q, quot_d;
  logic [SZW-1:0]  rem_q, rem_d;
  logic [SZW-1:0]  den_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [SZW:0]    trial;
  logic [SZW:0]    diff;
  logic            fits;

  assign trial  = {rem_q, quot_q[DVW-1]};
  assign fits   = trial >= {1'b0, den_q};
  assign diff   = trial - {1'b0, den_q};
  assign rem_d  = fits ? diff[SZW-1:0] : trial[SZW-1:0];
  assign quot_d = {quot_q[DVW-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNTW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

  // A new division must never be started on top of one in flight.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

@@ design/nnrs_front.sv @@
// Front end: size registers, frame loading, step computation and source address generation.
module nnrs_front import nnrs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_IDXW-1:0] cfg_index_i,
  input  logic [SZW-1:0]      cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic                q_full_i,
  output logic                op_push_o,
  output logic                op_write_o,
  output logic [AW-1:0]       op_addr_o,
  output pixel_t              op_data_o,
  output rd_flags_t           op_flags_o
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int PRODW = 2 * SZW;
  localparam int CMPW = (CW > PRODW) ? CW : PRODW;
  localparam int INTW = ACCW - FRACW;
  localparam logic [SZW-1:0] W_LIM = (MAX_WIDTH > SZ_MAX) ? SZW'(SZ_MAX) : SZW'(MAX_WIDTH);
  localparam logic [SZW-1:0] H_LIM = (MAX_HEIGHT > SZ_MAX) ? SZW'(SZ_MAX) : SZW'(MAX_HEIGHT);

  function automatic logic [SZW-1:0] clamp_sz(input logic [SZW-1:0] v,
                                              input logic [SZW-1:0] lim);
    logic [SZW-1:0] r;
    if (v == '0) begin
      r = SZW'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  front_state_e   state_q, state_d;

  logic [SZW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [SZW-1:0] sw, sh, tw, th;
  logic [SZW-1:0] sw_m1, sh_m1;
  logic [PRODW-1:0] frame_size;

  logic [CW-1:0]  load_cnt_q, load_cnt_d, cnt_after;
  logic           loaded_q, loaded_d;
  logic [ACCW-1:0] row_acc_q, row_acc_d, col_acc_q, col_acc_d;
  logic [SZW-1:0] dcol_q, dcol_d, drow_q, drow_d;
  logic [SZW:0]   dcol_inc, drow_inc;
  logic [DVW-1:0] row_step_q, col_step_q;
  logic [SZW-1:0] row_den_q, col_num_q, col_den_q;

  logic           in_fire, store_fire, fetch_fire;
  logic           can_store, load_done;
  logic           row_end, frame_end;
  logic [INTW-1:0] row_int;
  logic [INTW:0]  col_int;
  logic [SZW-1:0] srow, scol;
  logic [PRODW-1:0] pix_idx;

  logic           div_start;
  logic [DVW-1:0] div_num;
  logic [SZW-1:0] div_den;
  div_stat_t      div_stat;
  logic [DVW-1:0] div_quot;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SZW'(1);
      src_h_q <= SZW'(1);
      dst_w_q <= SZW'(1);
      dst_h_q <= SZW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SOURCE_WIDTH:  src_w_q <= cfg_data_i;
        REG_SOURCE_HEIGHT: src_h_q <= cfg_data_i;
        REG_TARGET_WIDTH:  dst_w_q <= cfg_data_i;
        REG_TARGET_HEIGHT: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sw = clamp_sz(src_w_q, W_LIM);
  assign sh = clamp_sz(src_h_q, H_LIM);
  assign tw = clamp_sz(dst_w_q, W_LIM);
  assign th = clamp_sz(dst_h_q, H_LIM);
  assign sw_m1 = sw - 1'b1;
  assign sh_m1 = sh - 1'b1;
  assign frame_size = PRODW'(sw) * PRODW'(sh);

  // Input handshake and item classification.
  assign in_fire    = in_valid_i && !in_stall_o;
  assign store_fire = in_fire && !kind_i;
  assign fetch_fire = in_fire && kind_i;

  assign can_store = !loaded_q && (CMPW'(load_cnt_q) < CMPW'(frame_size));
  assign cnt_after = can_store ? load_cnt_q + 1'b1 : load_cnt_q;
  assign load_done = store_fire && !loaded_q && (CMPW'(cnt_after) >= CMPW'(frame_size));

  // Source coordinates: the row truncates, the column rounds to the nearer pixel.
  assign row_int = row_acc_q[ACCW-1:FRACW];
  assign col_int = {1'b0, col_acc_q[ACCW-1:FRACW]} + (INTW+1)'(col_acc_q[FRACW-1]);
  assign srow = (row_int > INTW'(sh_m1)) ? sh_m1 : row_int[SZW-1:0];
  assign scol = (col_int > (INTW+1)'(sw_m1)) ? sw_m1 : col_int[SZW-1:0];
  assign pix_idx = PRODW'(srow) * PRODW'(sw) + PRODW'(scol);

  assign dcol_inc  = {1'b0, dcol_q} + 1'b1;
  assign drow_inc  = {1'b0, drow_q} + 1'b1;
  assign row_end   = dcol_inc >= {1'b0, tw};
  assign frame_end = row_end && (drow_inc >= {1'b0, th});

  always_comb begin
    load_cnt_d = load_cnt_q;
    loaded_d   = loaded_q;
    row_acc_d  = row_acc_q;
    col_acc_d  = col_acc_q;
    dcol_d     = dcol_q;
    drow_d     = drow_q;
    if (store_fire && can_store) begin
      load_cnt_d = cnt_after;
    end
    if (load_done) begin
      loaded_d  = 1'b1;
      row_acc_d = '0;
      col_acc_d = '0;
      dcol_d    = '0;
      drow_d    = '0;
    end
    if (fetch_fire && loaded_q) begin
      col_acc_d = col_acc_q + ACCW'(col_step_q);
      dcol_d    = dcol_inc[SZW-1:0];
      if (row_end) begin
        dcol_d    = '0;
        col_acc_d = '0;
        row_acc_d = row_acc_q + ACCW'(row_step_q);
        drow_d    = drow_inc[SZW-1:0];
        if (frame_end) begin
          drow_d     = '0;
          row_acc_d  = '0;
          loaded_d   = 1'b0;
          load_cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_RUN;
      load_cnt_q <= '0;
      loaded_q   <= 1'b0;
      row_acc_q  <= '0;
      col_acc_q  <= '0;
      dcol_q     <= '0;
      drow_q     <= '0;
      row_step_q <= '0;
      col_step_q <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      loaded_q   <= loaded_d;
      row_acc_q  <= row_acc_d;
      col_acc_q  <= col_acc_d;
      dcol_q     <= dcol_d;
      drow_q     <= drow_d;
      // A target size of one gives a zero step, the divisor is then zero.
      if (state_q == FS_DIV_ROW && div_stat.done) begin
        row_step_q <= (row_den_q == '0) ? '0 : div_quot;
      end
      if (state_q == FS_DIV_COL && div_stat.done) begin
        col_step_q <= (col_den_q == '0) ? '0 : div_quot;
      end
    end
  end

  // Sizes are captured when the frame completes so the column division uses them.
  always_ff @(posedge clk_i) begin
    if (load_done) begin
      row_den_q <= th - 1'b1;
      col_num_q <= sw_m1;
      col_den_q <= tw - 1'b1;
    end
  end

  // Step sequencer: the row step first, then the column step, on one divider.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_RUN: begin
        if (load_done) begin
          state_d = FS_DIV_ROW;
        end
      end
      FS_DIV_ROW: begin
        if (div_stat.done) begin
          state_d = FS_DIV_COL;
        end
      end
      FS_DIV_COL: begin
        if (div_stat.done) begin
          state_d = FS_RUN;
        end
      end
      default: state_d = FS_RUN;
    endcase
  end

  always_comb begin
    div_start  = 1'b0;
    div_num    = {sh_m1, {FRACW{1'b0}}};
    div_den    = th - 1'b1;
    in_stall_o = q_full_i || div_stat.busy;
    case (state_q)
      FS_RUN: begin
        div_start = load_done;
      end
      FS_DIV_ROW: begin
        div_start  = div_stat.done;
        div_num    = {col_num_q, {FRACW{1'b0}}};
        div_den    = col_den_q;
        in_stall_o = 1'b1;
      end
      FS_DIV_COL: begin
        in_stall_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  nnrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // Commands toward the back end.
  assign op_push_o  = (store_fire && can_store) || fetch_fire;
  assign op_write_o = !kind_i;
  assign op_data_o  = {red_i, green_i, blue_i};

  always_comb begin
    if (!kind_i) begin
      op_addr_o = AW'(load_cnt_q);
    end else if (loaded_q) begin
      op_addr_o = AW'(pix_idx);
    end else begin
      op_addr_o = '0;
    end
  end

  assign op_flags_o.last_in_row   = loaded_q && row_end;
  assign op_flags_o.last_in_frame = loaded_q && frame_end;
  assign op_flags_o.not_loaded    = !loaded_q;

endmodule

@@ design/nnrs_fifo.sv @@
// Short queue that decouples the front end from the back end.
module nnrs_fifo import nnrs_pkg::*; #(
  parameter int W = 52
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  logic [W-1:0]  slot_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = count_q == NW'(QDEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

@@ design/nnrs_back.sv @@
// Back end: frame memory writes and reads, and the output register.
module nnrs_back import nnrs_pkg::*; #(
  parameter int AW    = 16,
  parameter int DEPTH = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  logic          q_write_i,
  input  logic [AW-1:0] q_addr_i,
  input  pixel_t        q_data_i,
  input  rd_flags_t     q_flags_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_red_o,
  output logic [7:0]    out_green_o,
  output logic [7:0]    out_blue_o,
  output logic          last_in_row_o,
  output logic          last_in_frame_o,
  output logic          not_loaded_o
);

  pixel_t    frame_mem_q [DEPTH];
  pixel_t    rd_data_q;
  rd_flags_t flags_q;
  logic      out_valid_q;
  logic      wr_en, rd_en;
  logic      slot_free;

  // A read may only be issued when the output register is empty or draining.
  assign slot_free = !out_valid_q || !out_stall_i;
  assign q_pop_o   = !q_empty_i && (q_write_i || slot_free);
  assign wr_en     = q_pop_o && q_write_i;
  assign rd_en     = q_pop_o && !q_write_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem_q[q_addr_i] <= q_data_i;
    end
    if (rd_en) begin
      rd_data_q <= frame_mem_q[q_addr_i];
      flags_q   <= q_flags_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = flags_q.not_loaded ? 8'h00 : rd_data_q[23:16];
  assign out_green_o     = flags_q.not_loaded ? 8'h00 : rd_data_q[15:8];
  assign out_blue_o      = flags_q.not_loaded ? 8'h00 : rd_data_q[7:0];
  assign last_in_row_o   = flags_q.last_in_row;
  assign last_in_frame_o = flags_q.last_in_frame;
  assign not_loaded_o    = flags_q.not_loaded;

  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !(out_valid_q && out_stall_i))
    else $error("read issued over a held result");

endmodule

@@ design/nearest_neighbor_rgb_scaler_top.sv @@
// Top level of the nearest-neighbor RGB888 image scaler.
//
// Input channel (in_valid_i / in_stall_o): kind_i = 0 transfers one source
// pixel into the frame store in raster order, kind_i = 1 fetches the next
// destination pixel. Only fetches produce a transfer on the output channel
// (out_valid_o / out_stall_i). A fetch that comes before the frame is loaded
// returns not_loaded_o with zero color and flags.
// Sizes must be written on the configuration port only while the block is idle;
// the block itself does not enforce this. Items are taken one per cycle while
// in_stall_o is low. An accepted fetch passes through the queue and is read
// from the frame store into the output register. The store that completes a
// frame starts the step computation: one divider produces the row step and then
// the column step, 25 quotient bits each at one bit per cycle, and the input stalls meanwhile.
// Reset clears the load count, the loaded flag, the steps and the position;
// the frame store keeps no reset value. When the receiver stalls, the result
// is held in the output register; a two-entry queue keeps taking input until
// it fills, and then in_stall_o rises.
module nearest_neighbor_rgb_scaler_top import nnrs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_IDXW-1:0] cfg_index_i,
  input  logic [SZW-1:0]      cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_red_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_blue_o,
  output logic                last_in_row_o,
  output logic                last_in_frame_o,
  output logic                not_loaded_o
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $bits(rd_flags_t);
  localparam int QW = 1 + AW + PIXW + FW;

  logic          op_push, op_write;
  logic [AW-1:0] op_addr;
  pixel_t        op_data;
  rd_flags_t     op_flags;

  logic          q_full, q_empty, q_pop;
  logic [QW-1:0] q_head;
  logic          q_write;
  logic [AW-1:0] q_addr;
  pixel_t        q_data;
  rd_flags_t     q_flags;

  nnrs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .q_full_i    (q_full),
    .op_push_o   (op_push),
    .op_write_o  (op_write),
    .op_addr_o   (op_addr),
    .op_data_o   (op_data),
    .op_flags_o  (op_flags)
  );

  nnrs_fifo #(
    .W (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  ({op_write, op_addr, op_data, op_flags}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  assign {q_write, q_addr, q_data, q_flags} = q_head;

  nnrs_back #(
    .AW    (AW),
    .DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_write_i       (q_write),
    .q_addr_i        (q_addr),
    .q_data_i        (q_data),
    .q_flags_i       (q_flags),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .last_in_row_o   (last_in_row_o),
    .last_in_frame_o (last_in_frame_o),
    .not_loaded_o    (not_loaded_o)
  );

endmodule

@@ tb/tb_nearest_neighbor_rgb_scaler_top.sv @@
// Testbench for the nearest-neighbor RGB scaler: scoreboard class, drivers and checks.
module tb_nearest_neighbor_rgb_scaler_top;
  import nnrs_pkg::*;

  localparam int MaxWidth = 256;
  localparam int MaxHeight = 256;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int unsigned HalfPoint = 32768;
  localparam int unsigned FracMask = 'hffff;
  localparam bit KindStore = 1'b0;
  localparam bit KindFetch = 1'b1;
  localparam int SettleCycles = 64;
  localparam int DrainLimit = 20000;
  localparam int ItemTarget = 1525;
  localparam int ShapeWideSource = 0;
  localparam int ShapeTallSource = 1;
  localparam int ShapeTiny = 2;
  localparam int ShapeMedium = 3;
  localparam int PlanResizeLoading = 0;
  localparam int PlanResizeLoaded = 1;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
    logic       not_loaded;
  } scaled_pixel_t;

  class nn_scale_tracker;
    pixel_t          frame_store [StoreDepth];
    int unsigned     written_depth;
    int unsigned     load_count;
    bit              frame_loaded;
    int unsigned     row_step, column_step;
    int unsigned     row_acc, col_acc;
    int unsigned     dest_col, dest_row;
    logic [SZW-1:0]  size_reg [4];
    scaled_pixel_t   pending_pixels [$];
    int unsigned     mismatches;

    function new();
      written_depth = 0;
      load_count = 0;
      frame_loaded = 0;
      row_step = 0;
      column_step = 0;
      row_acc = 0;
      col_acc = 0;
      dest_col = 0;
      dest_row = 0;
      mismatches = 0;
      foreach (size_reg[i]) size_reg[i] = 1;
    endfunction

    function void write_size(cfg_reg_e idx, logic [SZW-1:0] value);
      size_reg[idx] = value;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int unsigned dim(cfg_reg_e idx);
      int unsigned top;
      top = (idx == REG_SOURCE_WIDTH || idx == REG_TARGET_WIDTH) ? MaxWidth : MaxHeight;
      return clamp(size_reg[idx], top);
    endfunction

    function int unsigned step_for(int unsigned src, int unsigned dst);
      if (dst <= 1) return 0;
      return ((src - 1) << FRACW) / (dst - 1);
    endfunction

    // New source sizes after a load may only address entries that hold data.
    function bit source_fits(logic [SZW-1:0] sw, logic [SZW-1:0] sh);
      if (!frame_loaded) return 1;
      return clamp(sw, MaxWidth) * clamp(sh, MaxHeight) <= written_depth;
    endfunction

    // Returns 1 when the item does something, 0 when the block drops it.
    function bit note_item(bit fetch, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned sw, sh, tw, th, srow, scol;
      scaled_pixel_t px;
      pixel_t word;
      sw = dim(REG_SOURCE_WIDTH);
      sh = dim(REG_SOURCE_HEIGHT);
      tw = dim(REG_TARGET_WIDTH);
      th = dim(REG_TARGET_HEIGHT);
      px = '{default: '0};
      if (fetch == KindStore) begin
        if (frame_loaded) return 0;
        if (load_count < sw * sh) begin
          frame_store[load_count] = {r, g, b};
          load_count++;
          if (load_count > written_depth) written_depth = load_count;
        end
        if (load_count >= sw * sh) begin
          frame_loaded = 1;
          row_step = step_for(sh, th);
          column_step = step_for(sw, tw);
          row_acc = 0;
          col_acc = 0;
          dest_col = 0;
          dest_row = 0;
        end
        return 1;
      end
      if (!frame_loaded) begin
        px.not_loaded = 1'b1;
        pending_pixels.push_back(px);
        return 1;
      end
      srow = row_acc >> FRACW;
      scol = col_acc >> FRACW;
      if ((col_acc & FracMask) >= HalfPoint) scol++;
      if (srow > sh - 1) srow = sh - 1;
      if (scol > sw - 1) scol = sw - 1;
      word = frame_store[(srow * sw + scol) % StoreDepth];
      col_acc += column_step;
      dest_col++;
      if (dest_col >= tw) begin
        px.row_end = 1'b1;
        dest_col = 0;
        col_acc = 0;
        row_acc += row_step;
        dest_row++;
        if (dest_row >= th) begin
          px.frame_end = 1'b1;
          dest_row = 0;
          row_acc = 0;
          frame_loaded = 0;
          load_count = 0;
        end
      end
      px.red = word[23:16];
      px.green = word[15:8];
      px.blue = word[7:0];
      pending_pixels.push_back(px);
      return 1;
    endfunction

    task report(string what);
      if (mismatches < 100) $display("ERROR: %s", what);
      mismatches++;
    endtask

    task check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                     logic row_end, logic frame_end, logic not_loaded);
      scaled_pixel_t want;
      if (pending_pixels.size() == 0) begin
        report("output transfer with no fetch outstanding");
        return;
      end
      want = pending_pixels.pop_front();
      if (r !== want.red) report($sformatf("out_red %h, expected %h", r, want.red));
      if (g !== want.green) report($sformatf("out_green %h, expected %h", g, want.green));
      if (b !== want.blue) report($sformatf("out_blue %h, expected %h", b, want.blue));
      if (row_end !== want.row_end)
        report($sformatf("last_in_row %b, expected %b", row_end, want.row_end));
      if (frame_end !== want.frame_end)
        report($sformatf("last_in_frame %b, expected %b", frame_end, want.frame_end));
      if (not_loaded !== want.not_loaded)
        report($sformatf("not_loaded %b, expected %b", not_loaded, want.not_loaded));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IDXW-1:0] cfg_index_i = '0;
  logic [SZW-1:0]      cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                kind_i = 1'b0;
  logic [7:0]          red_i = '0;
  logic [7:0]          green_i = '0;
  logic [7:0]          blue_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_red_o;
  logic [7:0]          out_green_o;
  logic [7:0]          out_blue_o;
  logic                last_in_row_o;
  logic                last_in_frame_o;
  logic                not_loaded_o;

  nn_scale_tracker tracker;
  bit calm = 1'b0;
  int effective_items = 0;

  nearest_neighbor_rgb_scaler_top #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .last_in_row_o  (last_in_row_o),
    .last_in_frame_o(last_in_frame_o),
    .not_loaded_o   (not_loaded_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void pick_sizes(input int shape, output logic [SZW-1:0] sw,
                                     output logic [SZW-1:0] sh, output logic [SZW-1:0] tw,
                                     output logic [SZW-1:0] th);
    case (shape)
      ShapeWideSource: begin
        sw = 9'd511; sh = 9'd0; tw = 9'd0; th = 9'd2;
      end
      ShapeTallSource: begin
        sw = 9'd0; sh = 9'd511; tw = 9'd511; th = 9'd1;
      end
      ShapeTiny: begin
        sw = 9'($urandom_range(0, 3));
        sh = 9'($urandom_range(0, 3));
        tw = 9'($urandom_range(0, 3));
        th = 9'($urandom_range(0, 3));
      end
      ShapeMedium: begin
        sw = 9'($urandom_range(8, 24));
        sh = 9'($urandom_range(1, 3));
        tw = 9'($urandom_range(8, 24));
        th = 9'($urandom_range(1, 3));
      end
      default: begin
        sw = 9'($urandom_range(1, 7));
        sh = 9'($urandom_range(1, 7));
        tw = 9'($urandom_range(1, 7));
        th = 9'($urandom_range(1, 7));
      end
    endcase
  endfunction

  task automatic send_item(input bit fetch, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= fetch;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (tracker.note_item(fetch, r, g, b)) effective_items++;
  endtask

  // Lets every outstanding result arrive, then covers the step division.
  task automatic drain_block();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (tracker.pending_pixels.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_sizes(input logic [SZW-1:0] sw, input logic [SZW-1:0] sh,
                               input logic [SZW-1:0] tw, input logic [SZW-1:0] th,
                               input bit with_source);
    logic [SZW-1:0] vals [4];
    vals[0] = sw;
    vals[1] = sh;
    vals[2] = tw;
    vals[3] = th;
    for (int i = with_source ? 0 : 2; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      tracker.write_size(cfg_reg_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_side
    int hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      tracker.check_pixel(out_red_o, out_green_o, out_blue_o,
                          last_in_row_o, last_in_frame_o, not_loaded_o);
    end
  end

  initial begin : stimulus
    logic [SZW-1:0] sw, sh, tw, th;
    int plan;
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes are 1x1: fetch before load, the completing store, a dropped store, a fetch.
    send_item(KindFetch, rand_byte(), rand_byte(), rand_byte());
    send_item(KindStore, 8'hff, 8'h00, 8'hff);
    send_item(KindStore, 8'h00, 8'hff, 8'h00);
    send_item(KindFetch, rand_byte(), rand_byte(), rand_byte());

    // 2x2 up to 3x3 puts the column fraction exactly on the rounding point.
    drain_block();
    program_sizes(9'd2, 9'd2, 9'd3, 9'd3, 1'b1);
    send_item(KindStore, 8'h00, 8'h00, 8'h00);
    send_item(KindStore, 8'hff, 8'hff, 8'hff);
    send_item(KindStore, 8'h80, 8'h7f, 8'h01);
    send_item(KindStore, 8'h55, 8'haa, 8'h5a);
    repeat (9) send_item(KindFetch, rand_byte(), rand_byte(), rand_byte());

    // Shrinking the frame mid-load: the next store completes it without a write.
    drain_block();
    program_sizes(9'd3, 9'd1, 9'd1, 9'd1, 1'b1);
    repeat (2) send_item(KindStore, rand_byte(), rand_byte(), rand_byte());
    drain_block();
    program_sizes(9'd0, 9'd0, 9'd1, 9'd1, 1'b1);
    send_item(KindStore, rand_byte(), rand_byte(), rand_byte());
    send_item(KindFetch, rand_byte(), rand_byte(), rand_byte());

    for (int frame = 0; effective_items < ItemTarget; frame++) begin
      calm = ($urandom_range(0, 4) == 0);
      plan = $urandom_range(0, 5);
      pick_sizes(frame < 2 ? frame : $urandom_range(ShapeTiny, 9), sw, sh, tw, th);
      drain_block();
      program_sizes(sw, sh, tw, th, 1'b1);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_item(KindFetch, rand_byte(), rand_byte(), rand_byte());
      if (plan == PlanResizeLoading) begin
        repeat ($urandom_range(0, 4))
          if (!tracker.frame_loaded) send_item(KindStore, rand_byte(), rand_byte(), rand_byte());
        pick_sizes($urandom_range(ShapeTiny, 9), sw, sh, tw, th);
        drain_block();
        program_sizes(sw, sh, tw, th, tracker.source_fits(sw, sh));
      end
      while (!tracker.frame_loaded) send_item(KindStore, rand_byte(), rand_byte(), rand_byte());
      if ($urandom_range(0, 3) == 0) send_item(KindStore, rand_byte(), rand_byte(), rand_byte());
      if (plan == PlanResizeLoaded) begin
        repeat ($urandom_range(0, 3))
          if (tracker.frame_loaded) send_item(KindFetch, rand_byte(), rand_byte(), rand_byte());
        pick_sizes($urandom_range(ShapeTiny, 9), sw, sh, tw, th);
        drain_block();
        program_sizes(sw, sh, tw, th, tracker.source_fits(sw, sh));
      end
      // Mostly fetches, with the odd store that the loaded block drops.
      while (tracker.frame_loaded)
        send_item($urandom_range(0, 9) != 0, rand_byte(), rand_byte(), rand_byte());
    end

    drain_block();
    if (tracker.pending_pixels.size() != 0)
      tracker.report($sformatf("%0d expected results never arrived",
                               tracker.pending_pixels.size()));
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
